// File: hw/rtl/s2p_pkg.sv
// ============================================================================
// s2p_pkg
// Shared types and constants for the serial-to-parallel handshake bridge.
// ============================================================================
`default_nettype none

package s2p_pkg;

  // Ring buffer depths and their pointer widths.
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  // Value on the data port while nothing is presented.
  localparam logic [7:0] IDLE_PORT = 8'h00;

  // Sticky error bit positions.
  localparam int ERR_FRAME    = 0;
  localparam int ERR_OVERRUN  = 1;
  localparam int ERR_OVERFLOW = 2;

  // Handshake machine phases.
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_HIGH = 2'd1,
    PH_WAIT_LOW  = 2'd2,
    PH_WAIT_ROOM = 2'd3
  } ph_t;

  // One input request.
  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_frame_error;
    logic       rx_overrun_error;
    logic       strobe_level;
    logic       tx_ready;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [7:0] data_port;
    logic       zero_marker;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] error_flags;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] err_bits;
    logic       strobe_level;
    logic       tx_ready;
  } cls_t;

endpackage

`default_nettype wire

// File: hw/rtl/s2p_ram.sv
// ============================================================================
// s2p_ram
// Simple dual-port RAM with registered, write-through read data.
// ============================================================================
`default_nettype none

module s2p_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same address in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/s2p_front.sv
// ============================================================================
// s2p_front
// Input side: accepts requests, classifies them and queues them for the back
// end in a two-entry queue.
// ============================================================================
`default_nettype none

module s2p_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire s2p_pkg::in_item_t  in_data,
  output logic                    cls_valid,
  input  wire logic               cls_ready,
  output s2p_pkg::cls_t           cls_data
);

  localparam logic [1:0] Q_FULL = 2'd2;

  s2p_pkg::cls_t q_r [2];
  s2p_pkg::cls_t cls_in;
  logic          wr_sel_r, wr_sel_nxt;
  logic          rd_sel_r, rd_sel_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  // Classify: error flags only count alongside a received byte.
  always_comb begin
    cls_in.rx_valid     = in_data.rx_valid;
    cls_in.rx_byte      = in_data.rx_byte;
    cls_in.err_bits     = {in_data.rx_overrun_error, in_data.rx_frame_error}
                          & {2{in_data.rx_valid}};
    cls_in.strobe_level = in_data.strobe_level;
    cls_in.tx_ready     = in_data.tx_ready;
  end

  assign in_ready  = (cnt_r != Q_FULL);
  assign cls_valid = (cnt_r != 2'd0);
  assign cls_data  = q_r[rd_sel_r];
  assign push      = in_valid && in_ready;
  assign pop       = cls_valid && cls_ready;

  // Queue pointer and fill count update.
  always_comb begin
    wr_sel_nxt = push ? ~wr_sel_r : wr_sel_r;
    rd_sel_nxt = pop ? ~rd_sel_r : rd_sel_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_sel_r] <= cls_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/s2p_back.sv
// ============================================================================
// s2p_back
// Execution side: receive ring buffer, strobe handshake machine, transmit
// ring buffer and the result register, one request per cycle while the result register can take it.
// ============================================================================
`default_nettype none

module s2p_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cls_valid,
  output logic                    cls_ready,
  input  wire s2p_pkg::cls_t      cls_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output s2p_pkg::out_item_t      out_data
);

  localparam int RAW = s2p_pkg::RX_AW;
  localparam int TAW = s2p_pkg::TX_AW;

  function automatic logic [RAW-1:0] rx_adv(input logic [RAW-1:0] p);
    rx_adv = (p == s2p_pkg::RX_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TAW-1:0] tx_adv(input logic [TAW-1:0] p);
    tx_adv = (p == s2p_pkg::TX_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [RAW-1:0]     rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [TAW-1:0]     tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic [2:0]         err_r, err_nxt;
  s2p_pkg::ph_t       phase_r, phase_nxt;
  logic [7:0]         held_r, held_nxt;
  logic [7:0]         port_r, port_nxt;
  logic               marker_r, marker_nxt;
  logic               out_valid_r, out_valid_nxt;
  s2p_pkg::out_item_t out_data_r, out_data_nxt;

  logic               go;
  logic [RAW-1:0]     rx_nh, rx_rp_adv, rx_wp_mid, rx_rd_addr;
  logic               rx_push, rx_full;
  logic [7:0]         rx_head, rx_rd_data;
  logic [TAW-1:0]     tx_nh, tx_rp_adv, tx_wp_mid, tx_rd_addr;
  logic               tx_room, echo;
  logic [7:0]         tx_head, tx_rd_data;
  logic               tx_v;
  logic [7:0]         tx_b;

  // The step advances whenever the result register is free or being drained.
  assign cls_ready = !out_valid_r || out_ready;
  assign go        = cls_valid && cls_ready;

  // Receive side: push, with overflow detection and sticky errors.
  always_comb begin
    rx_nh     = rx_adv(rx_wp_r);
    rx_full   = (rx_nh == rx_rp_r);
    rx_push   = go && cls_data.rx_valid && !rx_full;
    rx_wp_mid = rx_push ? rx_nh : rx_wp_r;
    rx_rp_adv = rx_adv(rx_rp_r);
    rx_head   = (rx_push && (rx_nh == rx_rp_adv)) ? cls_data.rx_byte : rx_rd_data;
    err_nxt   = err_r;
    if (go && cls_data.rx_valid) begin
      if (rx_full) begin
        err_nxt[s2p_pkg::ERR_OVERFLOW] = 1'b1;
      end else begin
        err_nxt[s2p_pkg::ERR_OVERRUN:s2p_pkg::ERR_FRAME] =
          err_r[s2p_pkg::ERR_OVERRUN:s2p_pkg::ERR_FRAME] | cls_data.err_bits;
      end
    end
  end

  // Handshake machine: next phase, held byte, port and marker.
  always_comb begin
    tx_nh      = tx_adv(tx_wp_r);
    tx_room    = (tx_nh != tx_rp_r);
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    port_nxt   = port_r;
    marker_nxt = marker_r;
    rx_rp_nxt  = rx_rp_r;
    echo       = 1'b0;
    if (go) begin
      case (phase_r)
        s2p_pkg::PH_IDLE: begin
          if (rx_wp_mid != rx_rp_r) begin
            rx_rp_nxt = rx_rp_adv;
            held_nxt  = rx_head;
            if (rx_head == 8'h00) begin
              marker_nxt = 1'b1;
            end else begin
              port_nxt = rx_head;
            end
            phase_nxt = s2p_pkg::PH_WAIT_HIGH;
          end
        end
        s2p_pkg::PH_WAIT_HIGH: begin
          if (cls_data.strobe_level) begin
            port_nxt   = s2p_pkg::IDLE_PORT;
            marker_nxt = 1'b0;
            phase_nxt  = s2p_pkg::PH_WAIT_LOW;
          end
        end
        s2p_pkg::PH_WAIT_LOW: begin
          if (!cls_data.strobe_level) begin
            if (tx_room) begin
              echo      = 1'b1;
              phase_nxt = s2p_pkg::PH_IDLE;
            end else begin
              phase_nxt = s2p_pkg::PH_WAIT_ROOM;
            end
          end
        end
        s2p_pkg::PH_WAIT_ROOM: begin
          if (tx_room) begin
            echo      = 1'b1;
            phase_nxt = s2p_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = s2p_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Transmit side: echo push, then one pop when the transmitter is ready.
  always_comb begin
    tx_wp_mid = echo ? tx_nh : tx_wp_r;
    tx_wp_nxt = tx_wp_mid;
    tx_rp_adv = tx_adv(tx_rp_r);
    tx_head   = (echo && (tx_nh == tx_rp_adv)) ? held_r : tx_rd_data;
    tx_rp_nxt = tx_rp_r;
    tx_v      = 1'b0;
    tx_b      = 8'h00;
    if (go && cls_data.tx_ready && (tx_wp_mid != tx_rp_r)) begin
      tx_rp_nxt = tx_rp_adv;
      tx_v      = 1'b1;
      tx_b      = tx_head;
    end
    rx_wp_nxt = rx_wp_mid;
  end

  // Result register.
  always_comb begin
    out_data_nxt.data_port   = port_nxt;
    out_data_nxt.zero_marker = marker_nxt;
    out_data_nxt.tx_valid    = tx_v;
    out_data_nxt.tx_byte     = tx_b;
    out_data_nxt.error_flags = err_nxt;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Both RAMs are always read at the current head entry of their buffer.
  assign rx_rd_addr = rst_n ? rx_adv(rx_rp_nxt) : rx_adv('0);
  assign tx_rd_addr = rst_n ? tx_adv(tx_rp_nxt) : tx_adv('0);

  s2p_ram #(
    .DEPTH (s2p_pkg::RX_DEPTH),
    .WIDTH (8)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_push),
    .wr_addr (rx_nh),
    .wr_data (cls_data.rx_byte),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd_data)
  );

  s2p_ram #(
    .DEPTH (s2p_pkg::TX_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (echo),
    .wr_addr (tx_nh),
    .wr_data (held_r),
    .rd_addr (tx_rd_addr),
    .rd_data (tx_rd_data)
  );

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      err_r       <= '0;
      phase_r     <= s2p_pkg::PH_IDLE;
      held_r      <= 8'h00;
      port_r      <= s2p_pkg::IDLE_PORT;
      marker_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      err_r       <= err_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      port_r      <= port_nxt;
      marker_r    <= marker_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/serial_to_parallel_handshake_bridge.sv
// ============================================================================
// serial_to_parallel_handshake_bridge
// Receive ring buffer, strobe handshake to a parallel port, and transmit echo.
// ============================================================================
// The bridge takes one request per clock while in_ready is high and returns
// exactly one result per request, in order: a request first enters a
// two-entry input queue, and from there the execution stage performs the
// receive push, one handshake step and one transmit pop together and loads
// the result register. Throughput is one request per cycle while the output
// side is not stalled, set by that single execution step; each ring buffer is a
// RAM that is read continuously at its head entry with write-through, so a
// byte pushed in a cycle can leave the buffer in the same cycle. Each buffer
// holds at most its depth minus one bytes. The error flags are sticky and are
// cleared only by reset.
`default_nettype none

module serial_to_parallel_handshake_bridge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire s2p_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output s2p_pkg::out_item_t      out_data
);

  logic          cls_valid;
  logic          cls_ready;
  s2p_pkg::cls_t cls_data;

  // Input queue and classification.
  s2p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  // Buffers, handshake machine and result register.
  s2p_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A byte is never on the data port while the zero marker is up.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.zero_marker && (out_data.data_port != 8'h00)))
    else $error("zero marker raised with a nonzero data port");

  // The transmit byte is zero whenever nothing is handed to the transmitter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tx_valid) |-> (out_data.tx_byte == 8'h00))
    else $error("transmit byte nonzero without transmit valid");

  // Error flags never clear between consecutive results.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid ||
      ((out_data.error_flags & $past(out_data.error_flags)) ==
       $past(out_data.error_flags))))
    else $error("sticky error flag cleared");

endmodule

`default_nettype wire
